>>> rtl/pcrc_pkg.sv
// ----------------------------------------------------------------------------
// pcrc_pkg
// shared types, register codes, reset values and the crc byte update
// ----------------------------------------------------------------------------
package pcrc_pkg;

    // register indexes on the configuration channel
    localparam logic [2:0] REG_DIRECTION      = 3'd0;
    localparam logic [2:0] REG_POLYNOMIAL     = 3'd1;
    localparam logic [2:0] REG_SEED           = 3'd2;
    localparam logic [2:0] REG_INVERT_OUT     = 3'd3;
    localparam logic [2:0] REG_PAYLOAD_LENGTH = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_CRC     = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    // direction codes
    localparam logic DIR_TRANSMIT = 1'b0;
    localparam logic DIR_RECEIVE  = 1'b1;

    // reset values of the registers and state
    localparam logic [15:0] POLY_RESET   = 16'h8005;
    localparam logic [15:0] SEED_RESET   = 16'hFFFF;
    localparam logic [7:0]  LENGTH_RESET = 8'd16;

    // result queue: holds the three results of a closing transmit byte
    // plus one more so a result can wait while the next request is taken
    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_PUSH    = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic       crc_ok;
        logic       last;
    } t_result;

    // msb-first crc-16 over one byte, feedback is crc[15] xor data bit
    function automatic logic [15:0] crc_byte(
        input logic [15:0] crc_in,
        input logic [7:0]  data,
        input logic [15:0] poly
    );
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int b = 7; b >= 0; b--) begin
            fb = c[15] ^ data[b];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/pcrc_if.sv
// ----------------------------------------------------------------------------
// pcrc_if
// valid/ready channels of the packet crc block: input, result, configuration
// ----------------------------------------------------------------------------
interface pcrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface pcrc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       crc_ok;
    logic       last;

    modport source (output valid, output out_byte, output byte_kind,
                    output crc_ok, output last, input ready);
    modport sink   (input valid, input out_byte, input byte_kind,
                    input crc_ok, input last, output ready);
endinterface

interface pcrc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/packet_crc16_append_check.sv
// ----------------------------------------------------------------------------
// packet_crc16_append_check
// crc-16 framing of fixed-length byte packets: append in transmit, check in
// receive
// path: a request waits in the input register, its results in the result queue
// throughput: one request per cycle while the queue has room; the last transmit
//   payload byte brings three results
// the limit is the result queue, which takes a request only with room for
//   three results after the current output pop
// reset (synchronous, active low): registers to their defaults, crc to all
//   ones, count and received high byte to zero, queue empty
// ----------------------------------------------------------------------------
module packet_crc16_append_check
    import pcrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcrc_in_if.sink    i_in,
    pcrc_out_if.source o_out,
    pcrc_cfg_if.sink   i_cfg
);

    // configuration registers
    logic        r_direction;
    logic [15:0] r_polynomial;
    logic [15:0] r_seed;
    logic        r_invert_out;
    logic [7:0]  r_payload_length;

    // packet state
    logic [15:0] r_crc_accum;
    logic [15:0] n_crc_accum;
    logic [8:0]  r_byte_count;
    logic [8:0]  n_byte_count;
    logic [7:0]  r_received_high;
    logic [7:0]  n_received_high;

    // input register stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // processing
    logic          proc_go;
    logic          q_room;
    logic          q_head_valid;
    t_result       q_head;
    logic [1:0]    push_n;
    t_result [2:0] push;
    logic [8:0]    len;
    logic [8:0]    cnt0;
    logic [8:0]    cnt1;
    logic [15:0]   crc_base;
    logic [15:0]   crc_next;
    logic [15:0]   crc_final;
    logic [15:0]   accum_final;

    // configuration channel never stalls
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction      <= DIR_TRANSMIT;
            r_polynomial     <= POLY_RESET;
            r_seed           <= SEED_RESET;
            r_invert_out     <= 1'b0;
            r_payload_length <= LENGTH_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DIRECTION:      r_direction      <= i_cfg.data[0];
                REG_POLYNOMIAL:     r_polynomial     <= i_cfg.data;
                REG_SEED:           r_seed           <= i_cfg.data;
                REG_INVERT_OUT:     r_invert_out     <= i_cfg.data[0];
                REG_PAYLOAD_LENGTH: r_payload_length <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // the held byte is processed once the queue has room for its results
    assign proc_go    = r_in_valid && q_room;
    assign i_in.ready = !r_in_valid || proc_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
        end
    end

    // length zero means a 256 byte payload
    assign len = (r_payload_length == 8'd0) ? 9'd256 : {1'b0, r_payload_length};

    // in transmit a count at or past the length restarts the packet
    assign cnt0 = (r_direction == DIR_TRANSMIT && r_byte_count >= len) ? 9'd0
                                                                       : r_byte_count;
    assign cnt1        = cnt0 + 9'd1;
    assign crc_base    = (cnt0 == 9'd0) ? r_seed : r_crc_accum;
    assign crc_next    = crc_byte(crc_base, r_in_byte, r_polynomial);
    assign crc_final   = r_invert_out ? ~crc_next : crc_next;
    assign accum_final = r_invert_out ? ~r_crc_accum : r_crc_accum;

    always_comb begin
        n_crc_accum     = r_crc_accum;
        n_byte_count    = r_byte_count;
        n_received_high = r_received_high;
        push_n          = 2'd0;
        push[0]         = '{out_byte: r_in_byte, byte_kind: KIND_PAYLOAD,
                            crc_ok: 1'b0, last: 1'b0};
        push[1]         = '{out_byte: crc_final[15:8], byte_kind: KIND_CRC,
                            crc_ok: 1'b0, last: 1'b0};
        push[2]         = '{out_byte: crc_final[7:0], byte_kind: KIND_CRC,
                            crc_ok: 1'b0, last: 1'b1};
        if (proc_go) begin
            if (r_direction == DIR_TRANSMIT) begin
                if (cnt1 < len) begin
                    // payload byte inside the packet
                    n_crc_accum  = crc_next;
                    n_byte_count = cnt1;
                    push_n       = 2'd1;
                end else begin
                    // closing payload byte: echo it and append the crc
                    n_crc_accum  = r_seed;
                    n_byte_count = 9'd0;
                    push_n       = 2'd3;
                end
            end else begin
                if (r_byte_count < len) begin
                    // receive payload byte
                    n_crc_accum  = crc_next;
                    n_byte_count = cnt1;
                    push_n       = 2'd1;
                end else if (r_byte_count == len) begin
                    // crc high byte, no result
                    n_received_high = r_in_byte;
                    n_byte_count    = cnt1;
                end else begin
                    // crc low byte gives the verdict
                    push[0] = '{out_byte: 8'd0, byte_kind: KIND_VERDICT,
                                crc_ok: ({r_received_high, r_in_byte} == accum_final),
                                last: 1'b1};
                    n_crc_accum  = r_seed;
                    n_byte_count = 9'd0;
                    push_n       = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_accum     <= SEED_RESET;
            r_byte_count    <= '0;
            r_received_high <= '0;
        end else begin
            r_crc_accum     <= n_crc_accum;
            r_byte_count    <= n_byte_count;
            r_received_high <= n_received_high;
        end
    end

    // result queue decouples the output from processing
    pcrc_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_n     (push_n),
        .i_push       (push),
        .i_pop_ready  (o_out.ready),
        .o_head_valid (q_head_valid),
        .o_head       (q_head),
        .o_room       (q_room)
    );

    assign o_out.valid     = q_head_valid;
    assign o_out.out_byte  = q_head.out_byte;
    assign o_out.byte_kind = q_head.byte_kind;
    assign o_out.crc_ok    = q_head.crc_ok;
    assign o_out.last      = q_head.last;

endmodule

>>> rtl/pcrc_outq.sv
// ----------------------------------------------------------------------------
// pcrc_outq
// small shift queue of results, takes up to three per cycle, gives one while ready
// ----------------------------------------------------------------------------
module pcrc_outq
    import pcrc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_push_n,
    input  t_result [2:0] i_push,
    input  logic          i_pop_ready,
    output logic          o_head_valid,
    output t_result       o_head,
    output logic          o_room
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    t_result r_q [QUEUE_DEPTH];
    t_result n_q [QUEUE_DEPTH];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          pop;
    logic [CW-1:0] base;
    logic [CW-1:0] slot;

    assign pop          = (r_cnt != '0) && i_pop_ready;
    assign base         = r_cnt - CW'(pop);
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[0];
    // room for a full burst of results after this cycle's pop
    assign o_room       = (32'(base) + MAX_PUSH) <= QUEUE_DEPTH;

    always_comb begin
        slot = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            n_q[k] = r_q[k];
        end
        if (pop) begin
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                n_q[k] = r_q[k + 1];
            end
        end
        for (int j = 0; j < MAX_PUSH; j++) begin
            slot = base + CW'(j);
            if (j < 32'(i_push_n)) begin
                n_q[slot[IW-1:0]] = i_push[j];
            end
        end
        n_cnt = base + CW'(i_push_n);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            r_q[k] <= n_q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule
